// ----- hw/rtl/hpg_pkg.sv -----
// ----------------------------------------------------------------------------
// Hermite pair gcd package
// Shared constants for the Hermite pair gcd degree block.
// ----------------------------------------------------------------------------
package hpg_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DEG_W     = 7;
  localparam int unsigned TDATA_W   = 16;
  localparam int unsigned MUL_STEPS = 32;
  localparam int unsigned MCNT_W    = 6;

  localparam logic [WORD_W-1:0] PRIME_RESET = 32'd2147483659;

  localparam logic [1:0] BANK_ROW0 = 2'd0;
  localparam logic [1:0] BANK_ROW1 = 2'd1;
  localparam logic [1:0] BANK_DIV  = 2'd2;

endpackage

// ----- hw/rtl/hermite_pair_gcd_degree_mod_p_top.sv -----
// ----------------------------------------------------------------------------
// Hermite pair gcd degree mod p
// Builds H_m and H_n over GF(p) and reports the degree of their gcd.
//
// Channel | Direction | Handshake              | Payload
// in      | slave     | in_tvalid / in_tready  | in_tdata: low_degree, high_degree
// out     | master    | out_tvalid / out_tready| out_tdata: gcd, expected, mismatch, bad
// cfg     | slave     | cfg_valid / cfg_ready  | cfg_data: prime_modulus
//
// Every modular product goes through one shift-add multiplier: 32 steps, plus operand load
// and write-back.
// A request runs a clear of the three row banks, the recurrence and then the Euclid steps.
// A malformed request goes straight from idle to the done state.
// Reset is synchronous and active low; the row memory is not cleared by reset.
// in_tready is high only while idle, cfg_ready only while idle with no request
// offered; a result waits in the output register.
// ----------------------------------------------------------------------------
module hermite_pair_gcd_degree_mod_p_top
  import hpg_pkg::*;
#(
  parameter int MAX_DEG = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // [6:0] low_degree, [13:7] high_degree, [15:14] zero
  input  logic [TDATA_W-1:0] in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  // [6:0] gcd_degree, [7] expected_degree, [8] mismatch, [9] bad_request
  output logic [TDATA_W-1:0] out_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [WORD_W-1:0]  cfg_data
);

  localparam int IW = $clog2(MAX_DEG + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_CLR,
    S_REC_RN, S_REC_MN, S_REC_WN, S_REC_RO, S_REC_MO, S_REC_WO,
    S_CPY_RD, S_CPY_WR,
    S_INV_RD, S_INV_LD, S_INV_CK, S_INV_WR, S_INV_WB,
    S_DIV_CK, S_DIV_RA, S_DIV_MC, S_DIV_WC,
    S_SUB_RB, S_SUB_MB, S_SUB_WB, S_SUB_RA, S_SUB_WA,
    S_DEC, S_SCAN_RD, S_SCAN_CK, S_DONE
  } state_t;

  state_t              state_r;
  logic [WORD_W-1:0]   prime_r;
  logic [IW-1:0]       m_r, n_r, k_r, j_r, db_r;
  logic [IW:0]         da_r;
  logic                exp_r, bad_r, ptr_r;
  logic [1:0]          clr_bank_r, a_bank_r, b_bank_r;
  logic [WORD_W-1:0]   ck_r, hi_r, base_r, rr_r, e_r, inv_r, c_r, t_r;
  logic [WORD_W-1:0]   ma_r, mb_r, acc_r;
  logic [MCNT_W-1:0]   mcnt_r;
  logic                out_tvalid_r;
  logic [TDATA_W-1:0]  out_tdata_r;

  logic [WORD_W-1:0]   mem [3][MAX_DEG+1];
  logic [WORD_W-1:0]   rdata_r;
  logic [1:0]          rd_bank, wr_bank;
  logic [IW-1:0]       rd_idx, wr_idx, sh_idx;
  logic                wr_en;
  logic [WORD_W-1:0]   wr_data;

  logic [WORD_W-1:0]   two, onep, ck_sum, mstep;
  logic [WORD_W+1:0]   mt, p1, p2;
  logic [WORD_W:0]     ck_add;
  logic                mdone, bad_in, last_j, db_neg_chk;
  logic [IW-1:0]       in_lo, in_hi;

  function automatic logic [WORD_W-1:0] msub(input logic [WORD_W-1:0] a,
                                             input logic [WORD_W-1:0] b,
                                             input logic [WORD_W-1:0] p);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, p} - {1'b0, b};
    return (a >= b) ? (a - b) : s[WORD_W-1:0];
  endfunction

  assign two      = (prime_r > 32'd2) ? 32'd2 : '0;
  assign onep     = (prime_r > 32'd1) ? 32'd1 : '0;
  assign ck_add   = {1'b0, ck_r} + {1'b0, two};
  assign ck_sum   = (ck_add >= {1'b0, prime_r}) ? WORD_W'(ck_add - {1'b0, prime_r})
                                                : ck_add[WORD_W-1:0];
  assign p1       = {2'b0, prime_r};
  assign p2       = {1'b0, prime_r, 1'b0};
  assign mt       = {1'b0, acc_r, 1'b0} + {2'b0, (mb_r[WORD_W-1] ? ma_r : '0)};
  assign mstep    = (mt >= p2) ? WORD_W'(mt - p2) :
                    (mt >= p1) ? WORD_W'(mt - p1) : mt[WORD_W-1:0];
  assign mdone    = (mcnt_r == '0);
  assign sh_idx   = IW'(j_r + da_r[IW-1:0] - db_r);
  assign last_j   = (j_r == IW'(k_r + 1'b1));
  assign in_lo    = IW'(in_tdata[DEG_W-1:0]);
  assign in_hi    = IW'(in_tdata[2*DEG_W-1:DEG_W]);
  assign bad_in   = (in_tdata[DEG_W-1:0] == '0) ||
                    (in_tdata[DEG_W-1:0] >= in_tdata[2*DEG_W-1:DEG_W]) ||
                    (32'(in_tdata[2*DEG_W-1:DEG_W]) > 32'(MAX_DEG)) ||
                    (prime_r == '0);
  assign db_neg_chk = ($signed(da_r) >= $signed({1'b0, db_r}));

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE) && !in_tvalid;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    rd_bank = '0;
    rd_idx  = '0;
    wr_en   = 1'b0;
    wr_bank = '0;
    wr_idx  = '0;
    wr_data = '0;
    case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_bank = clr_bank_r;
        wr_idx  = j_r;
        if (clr_bank_r == BANK_ROW0 && j_r == '0) begin
          wr_data = onep;
        end else if (clr_bank_r != BANK_ROW0 && j_r == IW'(1)) begin
          wr_data = two;
        end
      end
      S_REC_RN: begin
        rd_bank = {1'b0, ~ptr_r};
        rd_idx  = IW'(j_r - 1'b1);
      end
      S_REC_RO: begin
        rd_bank = {1'b0, ptr_r};
        rd_idx  = j_r;
      end
      S_REC_WO: begin
        wr_en   = mdone;
        wr_bank = {1'b0, ptr_r};
        wr_idx  = j_r;
        wr_data = msub(hi_r, acc_r, prime_r);
      end
      S_CPY_RD: begin
        rd_bank = {1'b0, ~ptr_r};
        rd_idx  = j_r;
      end
      S_CPY_WR: begin
        wr_en   = 1'b1;
        wr_bank = BANK_DIV;
        wr_idx  = j_r;
        wr_data = rdata_r;
      end
      S_INV_RD: begin
        rd_bank = b_bank_r;
        rd_idx  = db_r;
      end
      S_DIV_RA, S_SCAN_RD: begin
        rd_bank = a_bank_r;
        rd_idx  = da_r[IW-1:0];
      end
      S_SUB_RB: begin
        rd_bank = b_bank_r;
        rd_idx  = j_r;
      end
      S_SUB_RA: begin
        rd_bank = a_bank_r;
        rd_idx  = sh_idx;
      end
      S_SUB_WA: begin
        wr_en   = 1'b1;
        wr_bank = a_bank_r;
        wr_idx  = sh_idx;
        wr_data = msub(rdata_r, t_r, prime_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_bank][wr_idx] <= wr_data;
    end
    rdata_r <= mem[rd_bank][rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prime_r      <= PRIME_RESET;
      mcnt_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        prime_r <= cfg_data;
      end
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      if (!mdone) begin
        acc_r  <= mstep;
        mb_r   <= {mb_r[WORD_W-2:0], 1'b0};
        mcnt_r <= mcnt_r - 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            m_r        <= in_lo;
            n_r        <= in_hi;
            exp_r      <= in_tdata[0] & in_tdata[DEG_W];
            bad_r      <= bad_in;
            j_r        <= '0;
            clr_bank_r <= BANK_ROW0;
            state_r    <= bad_in ? S_DONE : S_CLR;
          end
        end
        S_CLR: begin
          if (j_r == IW'(MAX_DEG)) begin
            j_r <= '0;
            if (clr_bank_r == BANK_DIV) begin
              k_r     <= IW'(1);
              ptr_r   <= 1'b0;
              ck_r    <= two;
              state_r <= S_REC_RN;
            end else begin
              clr_bank_r <= clr_bank_r + 1'b1;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_REC_RN: begin
          if (j_r == '0) begin
            hi_r    <= '0;
            state_r <= S_REC_RO;
          end else begin
            state_r <= S_REC_MN;
          end
        end
        S_REC_MN: begin
          ma_r    <= rdata_r;
          mb_r    <= two;
          acc_r   <= '0;
          mcnt_r  <= MCNT_W'(MUL_STEPS);
          state_r <= S_REC_WN;
        end
        S_REC_WN: begin
          if (mdone) begin
            hi_r    <= acc_r;
            state_r <= S_REC_RO;
          end
        end
        S_REC_RO: state_r <= S_REC_MO;
        S_REC_MO: begin
          ma_r    <= rdata_r;
          mb_r    <= ck_r;
          acc_r   <= '0;
          mcnt_r  <= MCNT_W'(MUL_STEPS);
          state_r <= S_REC_WO;
        end
        S_REC_WO: begin
          if (mdone) begin
            if (last_j) begin
              ptr_r <= ~ptr_r;
              ck_r  <= ck_sum;
              j_r   <= '0;
              if (IW'(k_r + 1'b1) == m_r) begin
                state_r <= S_CPY_RD;
              end else if (IW'(k_r + 1'b1) == n_r) begin
                a_bank_r <= {1'b0, ptr_r};
                b_bank_r <= BANK_DIV;
                da_r     <= {1'b0, n_r};
                db_r     <= m_r;
                state_r  <= S_INV_RD;
              end else begin
                k_r     <= k_r + 1'b1;
                state_r <= S_REC_RN;
              end
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_REC_RN;
            end
          end
        end
        S_CPY_RD: state_r <= S_CPY_WR;
        S_CPY_WR: begin
          if (j_r == m_r) begin
            j_r     <= '0;
            k_r     <= k_r + 1'b1;
            state_r <= S_REC_RN;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_CPY_RD;
          end
        end
        S_INV_RD: state_r <= S_INV_LD;
        S_INV_LD: begin
          base_r  <= rdata_r;
          e_r     <= prime_r - 32'd2;
          rr_r    <= 32'd1;
          state_r <= S_INV_CK;
        end
        S_INV_CK: begin
          ma_r   <= base_r;
          acc_r  <= '0;
          if (e_r == '0) begin
            inv_r   <= rr_r;
            state_r <= S_DIV_CK;
          end else if (e_r[0]) begin
            mb_r    <= rr_r;
            mcnt_r  <= MCNT_W'(MUL_STEPS);
            state_r <= S_INV_WR;
          end else begin
            mb_r    <= base_r;
            mcnt_r  <= MCNT_W'(MUL_STEPS);
            state_r <= S_INV_WB;
          end
        end
        S_INV_WR: begin
          if (mdone) begin
            rr_r    <= acc_r;
            ma_r    <= base_r;
            mb_r    <= base_r;
            acc_r   <= '0;
            mcnt_r  <= MCNT_W'(MUL_STEPS);
            state_r <= S_INV_WB;
          end
        end
        S_INV_WB: begin
          if (mdone) begin
            base_r  <= acc_r;
            e_r     <= {1'b0, e_r[WORD_W-1:1]};
            state_r <= S_INV_CK;
          end
        end
        S_DIV_CK: begin
          if (db_neg_chk) begin
            state_r <= S_DIV_RA;
          end else begin
            a_bank_r <= b_bank_r;
            b_bank_r <= a_bank_r;
            da_r     <= {1'b0, db_r};
            db_r     <= da_r[IW-1:0];
            state_r  <= S_INV_RD;
          end
        end
        S_DIV_RA: state_r <= S_DIV_MC;
        S_DIV_MC: begin
          ma_r    <= rdata_r;
          mb_r    <= inv_r;
          acc_r   <= '0;
          mcnt_r  <= MCNT_W'(MUL_STEPS);
          state_r <= S_DIV_WC;
        end
        S_DIV_WC: begin
          if (mdone) begin
            c_r     <= acc_r;
            j_r     <= '0;
            state_r <= (acc_r != '0) ? S_SUB_RB : S_DEC;
          end
        end
        S_SUB_RB: state_r <= S_SUB_MB;
        S_SUB_MB: begin
          ma_r    <= rdata_r;
          mb_r    <= c_r;
          acc_r   <= '0;
          mcnt_r  <= MCNT_W'(MUL_STEPS);
          state_r <= S_SUB_WB;
        end
        S_SUB_WB: begin
          if (mdone) begin
            t_r     <= acc_r;
            state_r <= S_SUB_RA;
          end
        end
        S_SUB_RA: state_r <= S_SUB_WA;
        S_SUB_WA: begin
          if (j_r == db_r) begin
            state_r <= S_DEC;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_SUB_RB;
          end
        end
        S_DEC: begin
          da_r    <= da_r - 1'b1;
          state_r <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          state_r <= da_r[IW] ? S_DONE : S_SCAN_CK;
        end
        S_SCAN_CK: begin
          if (rdata_r == '0) begin
            da_r    <= da_r - 1'b1;
            state_r <= S_SCAN_RD;
          end else begin
            state_r <= S_DIV_CK;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            if (bad_r) begin
              out_tdata_r <= TDATA_W'(10'b10_0000_0000);
            end else begin
              out_tdata_r <= {6'b0, 1'b0, (db_r != IW'(exp_r)), exp_r, DEG_W'(db_r)};
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a request is in flight");
  a_bad_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tdata[8:0] == '0)
    else $error("rejected request carries nonzero fields");
  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    mcnt_r <= MCNT_W'(MUL_STEPS))
    else $error("multiplier step count out of range");
  a_sub_degree: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUB_WA |-> !da_r[IW])
    else $error("reduction step with negative remainder degree");
`endif

endmodule

// ----- test/tb_hermite_pair_gcd_degree_mod_p_top.sv -----
// ----------------------------------------------------------------------------
// Hermite pair gcd degree testbench
// Sends degree pairs under several field moduli and with random idle and stall
// patterns. Each result is checked against a local model of the Hermite
// recurrence and the Euclidean gcd over GF(p).
// ----------------------------------------------------------------------------
module tb_hermite_pair_gcd_degree_mod_p_top;
  import hpg_pkg::*;

  localparam int MAX_DEG = 64;

  typedef struct packed {
    logic [DEG_W-1:0] low_degree;
    logic [DEG_W-1:0] high_degree;
  } degree_pair_t;

  typedef struct packed {
    logic [DEG_W-1:0] gcd_degree;
    logic             expected_degree;
    logic             mismatch;
    logic             bad_request;
  } gcd_report_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [WORD_W-1:0]  cfg_data = '0;

  degree_pair_t pending_pairs[$];
  gcd_report_t  expected_reports[$];
  logic [WORD_W-1:0] field_modulus = PRIME_RESET;
  idle_mode_t idle_mode = IDLE_NONE;
  int  error_count = 0;
  bit  hold_request = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;

  hermite_pair_gcd_degree_mod_p_top #(.MAX_DEG(MAX_DEG)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] mul_mod(logic [31:0] a, logic [31:0] b, logic [31:0] p);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b);
    return 32'(prod % 64'(p));
  endfunction

  function automatic logic [31:0] sub_mod(logic [31:0] a, logic [31:0] b, logic [31:0] p);
    logic [63:0] r;
    r = (a >= b) ? 64'(a) - 64'(b) : 64'(a) + 64'(p) - 64'(b);
    return 32'(r);
  endfunction

  function automatic logic [31:0] fermat_inverse(logic [31:0] base, logic [31:0] p);
    logic [31:0] e;
    logic [31:0] r;
    e = p - 32'd2;
    r = 32'd1;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, base, p);
      base = mul_mod(base, base, p);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic gcd_report_t hermite_gcd_report(degree_pair_t pair, logic [31:0] p);
    logic [31:0] rows [2][MAX_DEG+1];
    logic [31:0] polys [2][MAX_DEG+1];
    logic [31:0] c, hi, inv;
    gcd_report_t rep;
    int m, n, k, j, od, nw, ai, bi, da, db, sh, td, tmp;
    m = pair.low_degree;
    n = pair.high_degree;
    rep = '0;
    if (m < 1 || m >= n || n > MAX_DEG || p == 0) begin
      rep.bad_request = 1'b1;
      return rep;
    end
    for (j = 0; j <= MAX_DEG; j++) begin
      rows[0][j] = '0;
      rows[1][j] = '0;
      polys[0][j] = '0;
      polys[1][j] = '0;
    end
    od = 0;
    nw = 1;
    rows[od][0] = 32'd1 % p;
    rows[nw][1] = 32'd2 % p;
    if (m == 1) polys[1] = rows[nw];
    for (k = 1; k < n; k++) begin
      c = mul_mod(32'd2 % p, 32'(k) % p, p);
      for (j = 0; j <= k + 1; j++) begin
        hi = (j >= 1) ? mul_mod(32'd2 % p, rows[nw][j-1], p) : 32'd0;
        rows[od][j] = sub_mod(hi, mul_mod(c, rows[od][j], p), p);
      end
      tmp = od; od = nw; nw = tmp;
      if (k + 1 == m) polys[1] = rows[nw];
    end
    polys[0] = rows[nw];
    ai = 0;
    bi = 1;
    da = n;
    db = m;
    forever begin
      inv = fermat_inverse(polys[bi][db], p);
      while (da >= db) begin
        c = mul_mod(polys[ai][da], inv, p);
        if (c != 0) begin
          sh = da - db;
          for (j = 0; j <= db; j++)
            polys[ai][j+sh] = sub_mod(polys[ai][j+sh], mul_mod(c, polys[bi][j], p), p);
        end
        da--;
        while (da >= 0 && polys[ai][da] == 0) da--;
        if (da < 0) break;
      end
      if (da < 0) break;
      tmp = ai; ai = bi; bi = tmp;
      td = da; da = db; db = td;
    end
    rep.gcd_degree = DEG_W'(db);
    rep.expected_degree = (m % 2 == 1) && (n % 2 == 1);
    rep.mismatch = (db != int'(rep.expected_degree));
    return rep;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      bit accepted;
      bit go_idle;
      accepted = in_tvalid && in_tready;
      if (accepted) begin
        expected_reports.push_back(hermite_gcd_report(pending_pairs[0], field_modulus));
        void'(pending_pairs.pop_front());
      end
      go_idle = (idle_mode == IDLE_SENDER && $urandom_range(99) < 71) ||
                (idle_mode == IDLE_BOTH && $urandom_range(99) < 16);
      if (in_tvalid && !accepted) begin
        in_tvalid <= 1'b1;
      end else if (pending_pairs.size() > 0 && !go_idle) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, pending_pairs[0].high_degree, pending_pairs[0].low_degree};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      gcd_report_t seen, want;
      if (out_tvalid && out_tready) begin
        seen.gcd_degree      = out_tdata[6:0];
        seen.expected_degree = out_tdata[7];
        seen.mismatch        = out_tdata[8];
        seen.bad_request     = out_tdata[9];
        if (expected_reports.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result transfer %h", out_tdata);
        end else begin
          want = expected_reports.pop_front();
          if (seen !== want || out_tdata[15:10] !== '0) begin
            error_count++;
            if (error_count <= 10)
              $display("result mismatch: expected gcd=%0d exp=%0b mis=%0b bad=%0b, got %h",
                       want.gcd_degree, want.expected_degree, want.mismatch,
                       want.bad_request, out_tdata);
          end
        end
      end
      if (hold_request && !hold_done) begin
        hold_done  <= 1'b1;
        hold_left  <= 3000;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (idle_mode == IDLE_RECEIVER) begin
        out_tready <= ($urandom_range(99) >= 71);
      end else if (idle_mode == IDLE_BOTH) begin
        out_tready <= ($urandom_range(99) >= 16);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_modulus(logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    field_modulus = value;
  endtask

  task automatic add_pair(int m, int n);
    degree_pair_t pair;
    pair.low_degree  = DEG_W'(m);
    pair.high_degree = DEG_W'(n);
    pending_pairs.push_back(pair);
  endtask

  task automatic add_random_pairs(int count);
    int i, m, n;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) begin
        add_pair($urandom_range(127), $urandom_range(127));
      end else begin
        n = ($urandom_range(39) == 0) ? $urandom_range(40, MAX_DEG) : $urandom_range(2, 12);
        m = $urandom_range(1, n - 1);
        add_pair(m, n);
      end
    end
  endtask

  task automatic drain;
    @(posedge clk);
    while (pending_pairs.size() > 0 || expected_reports.size() > 0 || in_tvalid || hold_left > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    #(64'd12 * 64'd60_000_000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    add_pair(0, 5);     add_pair(1, 2);    add_pair(5, 5);   add_pair(6, 5);
    add_pair(3, 65);    add_pair(127, 127); add_pair(0, 0);  add_pair(1, 127);
    add_pair(64, 64);   add_pair(2, 3);    add_pair(3, 5);   add_pair(4, 6);
    add_pair(7, 9);     add_pair(1, 3);    add_pair(63, 64); add_pair(2, 4);
    add_pair(85, 42);   add_pair(42, 85);
    drain();

    write_modulus(32'd3);
    idle_mode = IDLE_SENDER;
    add_pair(1, 64);
    add_random_pairs(20);
    drain();

    write_modulus(32'hFFFF_FFFF);
    idle_mode = IDLE_RECEIVER;
    hold_request = 1'b1;
    add_random_pairs(20);
    drain();

    write_modulus(32'd0);
    idle_mode = IDLE_BOTH;
    add_pair(1, 2);
    add_random_pairs(8);
    drain();

    write_modulus(32'd131);
    add_random_pairs(20);
    drain();

    write_modulus(PRIME_RESET);
    idle_mode = IDLE_NONE;
    add_random_pairs(20);
    drain();

    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/hpg_pkg.sv
hw/rtl/hermite_pair_gcd_degree_mod_p_top.sv
test/tb_hermite_pair_gcd_degree_mod_p_top.sv
